// File: rtl/core/kgd_pkg.sv
// Shared types, constants and codes of the key gesture detector.
// Used by the channel interfaces and every module under rtl/core.
package kgd_pkg;

	localparam int KEY_SLOTS_DEF = 8;
	localparam int TIME_BITS_DEF = 32;
	localparam int MAX_RESULTS   = 8;

	localparam int KEY_W      = 10;
	localparam int NOW_W      = 32;
	localparam int THR_W      = 16;
	localparam int GEN_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

	localparam int GE_CLICK  = 0;
	localparam int GE_DOUBLE = 1;
	localparam int GE_LONG   = 2;
	localparam int GE_SHORT  = 3;
	localparam int GE_TEST   = 4;

	localparam logic [KEY_W-1:0] FILTER_KEY_RST = '0;
	localparam logic [GEN_W-1:0] GESTURE_EN_RST = 5'd7;
	localparam logic [THR_W-1:0] HOLD_MS_RST    = 16'd250;
	localparam logic [THR_W-1:0] CLICK_WAIT_RST = 16'd200;
	localparam logic [THR_W-1:0] DBL_GAP_RST    = 16'd250;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_REPEAT  = 2'd2,
		OP_TIMEOUT = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		G_CLICK    = 3'd0,
		G_DOUBLE   = 3'd1,
		G_LONG     = 3'd2,
		G_SHORT    = 3'd3,
		G_DOWN     = 3'd4,
		G_UP       = 3'd5,
		G_OVERFLOW = 3'd6
	} gesture_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_EN  = 3'd0,
		CFG_FILTER_KEY = 3'd1,
		CFG_GESTURE_EN = 3'd2,
		CFG_HOLD_MS    = 3'd3,
		CFG_CLICK_WAIT = 3'd4,
		CFG_DBL_GAP    = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		SEL_HEAD   = 2'd0,
		SEL_SHORT  = 2'd1,
		SEL_SLOT   = 2'd2,
		SEL_DECIDE = 2'd3
	} emit_sel_t;

	typedef struct packed {
		logic             filter_enable;
		logic [KEY_W-1:0] filter_key;
		logic [GEN_W-1:0] gesture_enable;
		logic [THR_W-1:0] hold_ms;
		logic [THR_W-1:0] click_wait;
		logic [THR_W-1:0] dbl_gap;
	} cfg_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		emit_sel_t sel;
		logic      scan_step;
		logic      decide;
		logic      flush;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic is_press;
		logic is_timeout;
		logic head_emit;
		logic short_emit;
		logic slot_emit;
		logic dec_emit;
		logic can_emit;
		logic stage_valid;
		logic last_slot;
	} sts_t;

endpackage

// File: rtl/core/kgd_if.sv
// Channel interfaces: key events in, gestures out, register writes.
// Depends on kgd_pkg.
interface kgd_evt_if;
	import kgd_pkg::*;
	logic                    valid;
	logic                    ready;
	opcode_t                 opcode;
	logic [KEY_W-1:0]        key_id;
	logic [NOW_W-1:0]        now_ms;
	modport source (output valid, opcode, key_id, now_ms, input ready);
	modport sink (input valid, opcode, key_id, now_ms, output ready);
endinterface

interface kgd_res_if;
	import kgd_pkg::*;
	logic             valid;
	logic             ready;
	gesture_t         gesture;
	logic [KEY_W-1:0] gesture_key;
	logic             last;
	modport source (output valid, gesture, gesture_key, last, input ready);
	modport sink (input valid, gesture, gesture_key, last, output ready);
endinterface

interface kgd_cfg_if;
	import kgd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/kgd_cfg.sv
// Configuration register bank written over the register channel.
// Depends on kgd_pkg and kgd_cfg_if.
module kgd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	kgd_cfg_if.sink       cfg,
	output kgd_pkg::cfg_t regs
);
	import kgd_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.filter_enable  <= 1'b0;
			regs_q.filter_key     <= FILTER_KEY_RST;
			regs_q.gesture_enable <= GESTURE_EN_RST;
			regs_q.hold_ms        <= HOLD_MS_RST;
			regs_q.click_wait     <= CLICK_WAIT_RST;
			regs_q.dbl_gap        <= DBL_GAP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FILTER_EN:  regs_q.filter_enable  <= cfg.data[0];
				CFG_FILTER_KEY: regs_q.filter_key     <= cfg.data[KEY_W-1:0];
				CFG_GESTURE_EN: regs_q.gesture_enable <= cfg.data[GEN_W-1:0];
				CFG_HOLD_MS:    regs_q.hold_ms        <= cfg.data[THR_W-1:0];
				CFG_CLICK_WAIT: regs_q.click_wait     <= cfg.data[THR_W-1:0];
				CFG_DBL_GAP:    regs_q.dbl_gap        <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/kgd_datapath.sv
// Datapath: slot table memory, valid bits, elapsed-time compare,
// result staging and output register. Depends on kgd_pkg.
module kgd_datapath #(
	parameter int KEY_SLOTS = kgd_pkg::KEY_SLOTS_DEF,
	parameter int TIME_BITS = kgd_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kgd_pkg::cfg_t               regs,
	input  kgd_pkg::cmd_t               cmd,
	output kgd_pkg::sts_t               sts,
	input  kgd_pkg::opcode_t            evt_opcode,
	input  logic [kgd_pkg::KEY_W-1:0]   evt_key_id,
	input  logic [kgd_pkg::NOW_W-1:0]   evt_now_ms,
	output logic                        res_valid,
	output kgd_pkg::gesture_t           res_gesture,
	output logic [kgd_pkg::KEY_W-1:0]   res_gesture_key,
	output logic                        res_last,
	input  logic                        res_ready
);
	import kgd_pkg::*;

	localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	typedef logic [TIME_BITS-1:0] stamp_t;
	typedef logic [IDX_W-1:0]     idx_t;

	logic [KEY_W-1:0] key_mem [KEY_SLOTS];
	logic             rel_mem [KEY_SLOTS];
	stamp_t           stamp_mem [KEY_SLOTS];

	logic [KEY_SLOTS-1:0] valid_q;

	opcode_t          op_q;
	logic [KEY_W-1:0] key_q;
	stamp_t           now_q;
	idx_t             idx_q;
	logic             scan_done_q;
	logic [CNT_W-1:0] n_q;

	logic [KEY_W-1:0] rd_key_q;
	logic             rd_rel_q;
	stamp_t           rd_stamp_q;

	logic   found_q;
	idx_t   found_idx_q;
	logic   found_rel_q;
	stamp_t found_stamp_q;
	logic   free_found_q;
	idx_t   free_idx_q;

	logic             stage_valid_q;
	gesture_t         stage_gest_q;
	logic [KEY_W-1:0] stage_key_q;
	logic             res_valid_q;
	gesture_t         res_gest_q;
	logic [KEY_W-1:0] res_key_q;
	logic             res_last_q;

	idx_t             rd_addr;
	logic             last_slot;
	logic             cur_valid;
	logic             cur_match;
	stamp_t           stamp_sel;
	stamp_t           elapsed;
	logic             held;
	logic             dbl;
	logic             click_due;
	logic             slot_exp;
	logic             slot_en;
	logic             slot_emit;
	logic             slot_free;
	logic             room;
	logic             can_emit;

	logic             dec_wr;
	idx_t             dec_idx;
	logic             dec_rel;
	logic             dec_set;
	logic             dec_clr;
	logic             dec_emit;
	gesture_t         dec_code;

	gesture_t         new_gest;
	logic [KEY_W-1:0] new_key;

	assign last_slot = (idx_q == IDX_W'(KEY_SLOTS - 1));
	assign rd_addr   = (cmd.scan_step && !last_slot) ? idx_q + IDX_W'(1) : idx_q;
	assign cur_valid = valid_q[idx_q];
	assign cur_match = cur_valid && (rd_key_q == key_q);

	assign stamp_sel = scan_done_q ? found_stamp_q : rd_stamp_q;
	assign elapsed   = now_q - stamp_sel;
	assign held      = elapsed >= TIME_BITS'(regs.hold_ms);
	assign click_due = elapsed >= TIME_BITS'(regs.click_wait);
	assign dbl       = elapsed <= TIME_BITS'(regs.dbl_gap);

	assign room      = n_q < CNT_W'(MAX_RESULTS);
	assign slot_exp  = rd_rel_q ? click_due : held;
	assign slot_en   = rd_rel_q ? regs.gesture_enable[GE_CLICK] : regs.gesture_enable[GE_LONG];
	assign slot_emit = (op_q == OP_TIMEOUT) && cur_valid && slot_exp && slot_en && room;
	assign slot_free = (op_q == OP_TIMEOUT) && cur_valid && slot_exp && (!slot_en || room);
	assign can_emit  = !res_valid_q || res_ready;

	always_comb begin
		dec_wr   = 1'b0;
		dec_idx  = found_idx_q;
		dec_rel  = 1'b0;
		dec_set  = 1'b0;
		dec_clr  = 1'b0;
		dec_emit = 1'b0;
		dec_code = G_OVERFLOW;
		if (op_q == OP_PRESS) begin
			if (!found_q) begin
				if (free_found_q) begin
					dec_wr  = 1'b1;
					dec_idx = free_idx_q;
					dec_set = 1'b1;
				end else begin
					dec_emit = 1'b1;
				end
			end else if (found_rel_q) begin
				if (dbl) begin
					dec_clr  = 1'b1;
					dec_emit = regs.gesture_enable[GE_DOUBLE];
					dec_code = G_DOUBLE;
				end else begin
					dec_wr   = 1'b1;
					dec_emit = regs.gesture_enable[GE_CLICK];
					dec_code = G_CLICK;
				end
			end
		end else if (op_q == OP_RELEASE && found_q && !found_rel_q) begin
			if (!held) begin
				dec_wr  = 1'b1;
				dec_rel = 1'b1;
			end else begin
				dec_clr = 1'b1;
			end
		end
	end

	always_comb begin
		new_gest = dec_code;
		new_key  = key_q;
		case (cmd.sel)
			SEL_HEAD:   new_gest = (op_q == OP_PRESS) ? G_DOWN : G_UP;
			SEL_SHORT:  new_gest = G_SHORT;
			SEL_SLOT: begin
				new_gest = rd_rel_q ? G_CLICK : G_LONG;
				new_key  = rd_key_q;
			end
			SEL_DECIDE: new_gest = dec_code;
			default:    new_gest = dec_code;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && dec_wr) begin
			key_mem[dec_idx]   <= key_q;
			rel_mem[dec_idx]   <= dec_rel;
			stamp_mem[dec_idx] <= now_q;
		end
		rd_key_q   <= key_mem[rd_addr];
		rd_rel_q   <= rel_mem[rd_addr];
		rd_stamp_q <= stamp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.scan_step && slot_free) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (cmd.decide && dec_set) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.decide && dec_clr) begin
				valid_q[found_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= evt_opcode;
			key_q <= evt_key_id;
			now_q <= TIME_BITS'(evt_now_ms);
		end
		if (cmd.scan_step && !found_q && cur_match) begin
			found_idx_q   <= idx_q;
			found_rel_q   <= rd_rel_q;
			found_stamp_q <= rd_stamp_q;
		end
		if (cmd.scan_step && !free_found_q && !cur_valid) begin
			free_idx_q <= idx_q;
		end
		if (cmd.emit) begin
			stage_gest_q <= new_gest;
			stage_key_q  <= new_key;
		end
		if ((cmd.emit && stage_valid_q) || cmd.flush) begin
			res_gest_q <= stage_gest_q;
			res_key_q  <= stage_key_q;
			res_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			scan_done_q   <= 1'b0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			n_q           <= '0;
			stage_valid_q <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q        <= '0;
				scan_done_q  <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				n_q          <= '0;
			end else if (cmd.scan_step) begin
				if (last_slot) begin
					scan_done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (cur_match) begin
					found_q <= 1'b1;
				end
				if (!cur_valid) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				n_q <= n_q + CNT_W'(1);
			end

			if ((cmd.emit && stage_valid_q) || cmd.flush) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (cmd.emit) begin
				stage_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				stage_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid       = res_valid_q;
	assign res_gesture     = res_gest_q;
	assign res_gesture_key = res_key_q;
	assign res_last        = res_last_q;

	assign sts.drop        = (op_q == OP_REPEAT) ||
	                         ((op_q != OP_TIMEOUT) && regs.filter_enable &&
	                          (key_q != regs.filter_key));
	assign sts.is_press    = (op_q == OP_PRESS);
	assign sts.is_timeout  = (op_q == OP_TIMEOUT);
	assign sts.head_emit   = regs.gesture_enable[GE_TEST];
	assign sts.short_emit  = regs.gesture_enable[GE_SHORT];
	assign sts.slot_emit   = slot_emit;
	assign sts.dec_emit    = dec_emit;
	assign sts.can_emit    = can_emit;
	assign sts.stage_valid = stage_valid_q;
	assign sts.last_slot   = last_slot;

endmodule

// File: rtl/core/kgd_ctrl.sv
// Controller: sequences one item through head results, slot scan,
// decision and final flush. Depends on kgd_pkg.
module kgd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	output logic          evt_ready,
	input  kgd_pkg::sts_t sts,
	output kgd_pkg::cmd_t cmd
);
	import kgd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SHORT,
		ST_SCAN,
		ST_DECIDE,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign evt_ready = ready_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = evt_valid && ready_q;
			ST_HEAD: begin
				if (!sts.drop && !sts.is_timeout && sts.head_emit && sts.can_emit) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_HEAD;
				end
			end
			ST_SHORT: begin
				if (sts.short_emit && sts.can_emit) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_SHORT;
				end
			end
			ST_SCAN: begin
				if (!sts.slot_emit || sts.can_emit) begin
					cmd.scan_step = 1'b1;
					cmd.emit      = sts.slot_emit;
					cmd.sel       = SEL_SLOT;
				end
			end
			ST_DECIDE: begin
				if (!sts.dec_emit || sts.can_emit) begin
					cmd.decide = 1'b1;
					cmd.emit   = sts.dec_emit;
					cmd.sel    = SEL_DECIDE;
				end
			end
			ST_FLUSH: cmd.flush = sts.stage_valid && sts.can_emit;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_HEAD;
						ready_q <= 1'b0;
					end
				end
				ST_HEAD: begin
					if (sts.drop) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end else if (sts.is_timeout) begin
						state_q <= ST_SCAN;
					end else if (!sts.head_emit || sts.can_emit) begin
						state_q <= sts.is_press ? ST_SHORT : ST_SCAN;
					end
				end
				ST_SHORT: begin
					if (!sts.short_emit || sts.can_emit) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmd.scan_step && sts.last_slot) begin
						state_q <= sts.is_timeout ? ST_FLUSH : ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (cmd.decide) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!sts.stage_valid || sts.can_emit) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/key_gesture_detector_core.sv
// Key gesture detector top level: one item at a time, one slot per scan cycle
// while no slot result waits for the output register. A press passes head,
// short, slot scan, decision and flush; a release skips short; a timeout
// check has only the slot scan and flush; a repeat or filtered key is dropped.
// Reset: registers return to defaults, table empty, no result pending.
module key_gesture_detector_core #(
	parameter int KEY_SLOTS = kgd_pkg::KEY_SLOTS_DEF,
	parameter int TIME_BITS = kgd_pkg::TIME_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kgd_evt_if.sink   evt,
	kgd_res_if.source res,
	kgd_cfg_if.sink   cfg
);
	import kgd_pkg::*;

	cfg_t regs;
	cmd_t cmd;
	sts_t sts;

	kgd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	kgd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kgd_datapath #(
		.KEY_SLOTS (KEY_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.regs            (regs),
		.cmd             (cmd),
		.sts             (sts),
		.evt_opcode      (evt.opcode),
		.evt_key_id      (evt.key_id),
		.evt_now_ms      (evt.now_ms),
		.res_valid       (res.valid),
		.res_gesture     (res.gesture),
		.res_gesture_key (res.gesture_key),
		.res_last        (res.last),
		.res_ready       (res.ready)
	);

	a_emit_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.can_emit)
		else $error("result pushed while output register blocked");

	a_idle_stage_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && evt.ready) |-> !sts.stage_valid)
		else $error("new item accepted with a staged result left over");

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (res.valid && res.last))
		else $error("final transfer of an item not marked last");

endmodule
